>>> hw/rtl/kce_pkg.sv
// Shared types and constants for the keystroke cursor editor.
package kce_pkg;

   // Key codes.
   localparam logic [7:0] KEY_BACKSPACE = 8'h08;
   localparam logic [7:0] KEY_UP        = 8'hE0;
   localparam logic [7:0] KEY_DOWN      = 8'hE1;
   localparam logic [7:0] KEY_LEFT      = 8'hE2;
   localparam logic [7:0] KEY_RIGHT     = 8'hE3;
   localparam logic [7:0] PRINT_LOW     = 8'h20;
   localparam logic [7:0] PRINT_HIGH    = 8'h7E;

   // Display bytes.
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] LINE1_BASE    = 8'h40;
   localparam logic [7:0] CMD_SET_ADDR  = 8'h80;

   // What the back end has to emit for one keystroke.
   typedef enum logic [1:0] {
      OP_BACKSPACE,   // set cursor, space, set cursor
      OP_CURSOR,      // set cursor
      OP_PRINT,       // character data
      OP_PRINT_WRAP   // character data, set cursor
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] key_char;   // character for the data write
      logic [7:0] set_cmd;    // set-cursor command for the new cursor
   } entry_type;

endpackage

>>> hw/rtl/keystroke_lcd_cursor_editor_unit.sv
// Top level of the keystroke cursor editor for a two-line character display.
//
//   channel | direction | beat contents                        | handshake
//   req_    | in        | key_code                             | req_valid / req_ready
//   rsp_    | out       | is_char_data, out_byte, last_write   | rsp_valid / rsp_ready
//
// A key beat is accepted whenever the two-entry queue has room, so keys may
// arrive back to back. Each key yields zero to three display writes, which
// leave one per cycle from the output register while rsp_ready is high; the
// write sequencer in the back end emits one, two or three writes per key that
// acts (backspace takes three). Reset clears the cursor to the upper line,
// column zero, and empties the queue and output register. A stalled rsp_ready
// holds the current write while keys keep filling the queue until it is full.
module keystroke_lcd_cursor_editor_unit #(
   parameter int LINE_COLUMNS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_key_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_char_data,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_write
);

   // Classified keystroke handed from the front end to the queue.
   logic               push;
   kce_pkg::entry_type push_entry;
   logic               queue_full;

   // Head of the queue as seen by the back end.
   logic               head_valid;
   kce_pkg::entry_type head_entry;
   logic               pop;

   // The front end owns the cursor. It computes the cursor after each key up
   // front, so the back end only has to replay the stored set-cursor command.
   kce_front #(
      .LINE_COLUMNS (LINE_COLUMNS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_key_code (req_key_code),
      .queue_full   (queue_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Keys that cause no write are accepted but never enter the queue.
   kce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // The back end steps through the writes of the head entry and pops it on
   // the write that carries last_write.
   kce_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_char_data (rsp_is_char_data),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_write   (rsp_last_write)
   );

endmodule

>>> hw/rtl/kce_front.sv
// Front end: takes key codes, tracks the cursor and classifies each key.
module kce_front #(
   parameter int LINE_COLUMNS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_key_code,
   input  logic                queue_full,
   output logic                push,
   output kce_pkg::entry_type  push_entry
);

   localparam int ColW = (LINE_COLUMNS > 2) ? $clog2(LINE_COLUMNS) : 1;
   localparam logic [ColW-1:0] LastCol = ColW'(LINE_COLUMNS - 1);

   logic            cursor_line_ff, cursor_line_in;
   logic [ColW-1:0] cursor_col_ff, cursor_col_in;
   logic            accept;
   logic            has_writes;
   kce_pkg::op_type op;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cursor_line_in = cursor_line_ff;
      cursor_col_in  = cursor_col_ff;
      has_writes     = 1'b0;
      op             = kce_pkg::OP_CURSOR;
      case (req_key_code) inside
         kce_pkg::KEY_BACKSPACE: begin
            has_writes = 1'b1;
            op         = kce_pkg::OP_BACKSPACE;
            if (cursor_col_ff != '0) begin
               cursor_col_in = cursor_col_ff - 1'b1;
            end else if (cursor_line_ff) begin
               cursor_line_in = 1'b0;
               cursor_col_in  = LastCol;
            end
         end
         kce_pkg::KEY_UP: begin
            has_writes     = 1'b1;
            cursor_line_in = 1'b0;
         end
         kce_pkg::KEY_DOWN: begin
            has_writes     = 1'b1;
            cursor_line_in = 1'b1;
         end
         kce_pkg::KEY_LEFT: begin
            has_writes = 1'b1;
            if (cursor_col_ff != '0) begin
               cursor_col_in = cursor_col_ff - 1'b1;
            end else begin
               cursor_line_in = !cursor_line_ff;
               cursor_col_in  = LastCol;
            end
         end
         kce_pkg::KEY_RIGHT: begin
            has_writes = 1'b1;
            if (cursor_col_ff != LastCol) begin
               cursor_col_in = cursor_col_ff + 1'b1;
            end else begin
               cursor_line_in = !cursor_line_ff;
               cursor_col_in  = '0;
            end
         end
         [kce_pkg::PRINT_LOW:kce_pkg::PRINT_HIGH]: begin
            has_writes = 1'b1;
            if (cursor_col_ff != LastCol) begin
               op            = kce_pkg::OP_PRINT;
               cursor_col_in = cursor_col_ff + 1'b1;
            end else begin
               op             = kce_pkg::OP_PRINT_WRAP;
               cursor_line_in = !cursor_line_ff;
               cursor_col_in  = '0;
            end
         end
         default: ;
      endcase
   end

   // The set-cursor command always reflects the cursor after this key.
   assign push_entry.op       = op;
   assign push_entry.key_char = req_key_code;
   assign push_entry.set_cmd  = kce_pkg::CMD_SET_ADDR | 8'(cursor_col_in)
                                | (cursor_line_in ? kce_pkg::LINE1_BASE : 8'h00);
   assign push = accept && has_writes;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_line_ff <= 1'b0;
         cursor_col_ff  <= '0;
      end else if (accept) begin
         cursor_line_ff <= cursor_line_in;
         cursor_col_ff  <= cursor_col_in;
      end
   end

endmodule

>>> hw/rtl/kce_queue.sv
// Two-entry queue of classified keystrokes between front and back end.
module kce_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  kce_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output kce_pkg::entry_type  head_entry
);

   localparam int Depth = 2;

   kce_pkg::entry_type entries_ff [Depth];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == 2'(Depth));
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = entries_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/kce_back.sv
// Back end: turns queued keys into display writes, one a cycle unless stalled.
module kce_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  kce_pkg::entry_type  head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_is_char_data,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_write
);

   logic [1:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       is_data_ff, is_data_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load;
   logic       wr_data;
   logic [7:0] wr_byte;
   logic       wr_last;

   // Write selected by the current step of the head entry.
   always_comb begin
      wr_data = 1'b0;
      wr_byte = head_entry.set_cmd;
      wr_last = 1'b1;
      case (head_entry.op)
         kce_pkg::OP_BACKSPACE: begin
            wr_last = (step_ff == 2'd2);
            if (step_ff == 2'd1) begin
               wr_data = 1'b1;
               wr_byte = kce_pkg::CHAR_SPACE;
            end
         end
         kce_pkg::OP_CURSOR: ;
         kce_pkg::OP_PRINT: begin
            wr_data = 1'b1;
            wr_byte = head_entry.key_char;
         end
         kce_pkg::OP_PRINT_WRAP: begin
            wr_last = (step_ff == 2'd1);
            if (step_ff == 2'd0) begin
               wr_data = 1'b1;
               wr_byte = head_entry.key_char;
            end
         end
         default: ;
      endcase
   end

   assign load = !rsp_valid_ff || rsp_ready;
   assign pop  = load && head_valid && wr_last;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      is_data_in   = is_data_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            is_data_in = wr_data;
            byte_in    = wr_byte;
            last_in    = wr_last;
            step_in    = wr_last ? 2'd0 : step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_data_ff <= is_data_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_char_data = is_data_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_last_write   = last_ff;

endmodule

>>> hw/rtl/kce_checker.sv
// Port-level checks for the keystroke cursor editor, bound to the top level.
module kce_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_key_code,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_char_data,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_write
);

   // No write is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("write offered right after reset");

   // A stalled write holds its beat.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_char_data)
      && $stable(rsp_out_byte) && $stable(rsp_last_write))
      else $error("stalled write changed");

   // Every command write is a set-cursor command.
   a_cmd_is_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_char_data |-> rsp_out_byte[7])
      else $error("command write without set-cursor bit");

   // Character data is always printable.
   a_data_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_char_data |->
      rsp_out_byte >= kce_pkg::PRINT_LOW && rsp_out_byte <= kce_pkg::PRINT_HIGH)
      else $error("data write outside printable range");

   // A non-final data write only occurs as the space of a backspace or as the
   // character before a wrap, so the next write is always a command.
   a_data_then_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_is_char_data && !rsp_last_write
      ##1 rsp_valid |-> !rsp_is_char_data)
      else $error("data write followed by data within one key");

endmodule

bind keystroke_lcd_cursor_editor_unit kce_checker u_kce_checker (.*);

>>> tb/cursor_write_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the display writes caused by each keystroke.
`timescale 1ns / 100ps
package cursor_write_scoreboard_pkg;

   class cursor_write_scoreboard;
      typedef struct {
         logic       is_data;
         logic [7:0] wr_byte;
         logic       last;
      } display_write_type;

      display_write_type due_writes[$];
      bit                cur_line;
      int unsigned       cur_column;
      int unsigned       columns;
      int                errors;
      int                keys_noted;
      int                ignored_keys;
      int                writes_checked;
      int                line_wraps;
      int                backspace_home;
      int                backspace_wrap;

      function new(int unsigned line_columns);
         columns    = line_columns;
         cur_line   = 1'b0;
         cur_column = 0;
      endfunction

      function logic [7:0] set_cursor_cmd();
         logic [7:0] addr;
         addr = (cur_line ? kce_pkg::LINE1_BASE : 8'h00) + 8'(cur_column);
         return kce_pkg::CMD_SET_ADDR | (addr & 8'h7F);
      endfunction

      function void push_write(logic is_data, logic [7:0] wr_byte, logic last);
         display_write_type w;
         w.is_data = is_data;
         w.wr_byte = wr_byte;
         w.last    = last;
         due_writes.push_back(w);
      endfunction

      // Advances the cursor for one accepted key and queues the writes it must cause.
      function void note_key(logic [7:0] key);
         kce_pkg::op_type op;
         bit              acts;
         acts = 1'b1;
         op   = kce_pkg::OP_CURSOR;
         keys_noted++;
         case (key)
            kce_pkg::KEY_BACKSPACE: op = kce_pkg::OP_BACKSPACE;
            kce_pkg::KEY_UP, kce_pkg::KEY_DOWN, kce_pkg::KEY_LEFT, kce_pkg::KEY_RIGHT:
               op = kce_pkg::OP_CURSOR;
            default: begin
               if (key >= kce_pkg::PRINT_LOW && key <= kce_pkg::PRINT_HIGH)
                  op = (cur_column == columns - 1) ? kce_pkg::OP_PRINT_WRAP
                                                   : kce_pkg::OP_PRINT;
               else
                  acts = 1'b0;
            end
         endcase
         if (!acts) begin
            ignored_keys++;
            return;
         end
         case (op)
            kce_pkg::OP_BACKSPACE: begin
               if (cur_column > 0) begin
                  cur_column--;
               end else if (cur_line) begin
                  cur_line   = 1'b0;
                  cur_column = columns - 1;
                  backspace_wrap++;
               end else begin
                  backspace_home++;
               end
               push_write(1'b0, set_cursor_cmd(), 1'b0);
               push_write(1'b1, kce_pkg::CHAR_SPACE, 1'b0);
               push_write(1'b0, set_cursor_cmd(), 1'b1);
            end
            kce_pkg::OP_CURSOR: begin
               if (key == kce_pkg::KEY_UP) begin
                  cur_line = 1'b0;
               end else if (key == kce_pkg::KEY_DOWN) begin
                  cur_line = 1'b1;
               end else if (key == kce_pkg::KEY_LEFT) begin
                  if (cur_column > 0) begin
                     cur_column--;
                  end else begin
                     cur_line   = ~cur_line;
                     cur_column = columns - 1;
                  end
               end else begin
                  if (cur_column < columns - 1) begin
                     cur_column++;
                  end else begin
                     cur_line   = ~cur_line;
                     cur_column = 0;
                  end
               end
               push_write(1'b0, set_cursor_cmd(), 1'b1);
            end
            kce_pkg::OP_PRINT: begin
               cur_column++;
               push_write(1'b1, key, 1'b1);
            end
            default: begin
               cur_column = 0;
               cur_line   = ~cur_line;
               line_wraps++;
               push_write(1'b1, key, 1'b0);
               push_write(1'b0, set_cursor_cmd(), 1'b1);
            end
         endcase
      endfunction

      function void check_write(logic is_data, logic [7:0] wr_byte, logic last);
         display_write_type w;
         if (due_writes.size() == 0) begin
            $error("display write with none due: is_char_data %0b out_byte %02h last_write %0b",
                   is_data, wr_byte, last);
            errors++;
            return;
         end
         w = due_writes.pop_front();
         writes_checked++;
         if (is_data !== w.is_data) begin
            $error("is_char_data expected %0b got %0b", w.is_data, is_data);
            errors++;
         end
         if (wr_byte !== w.wr_byte) begin
            $error("out_byte expected %02h got %02h", w.wr_byte, wr_byte);
            errors++;
         end
         if (last !== w.last) begin
            $error("last_write expected %0b got %0b", w.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return due_writes.size();
      endfunction
   endclass

endpackage

>>> tb/keystroke_lcd_cursor_editor_unit_tb.sv
// Top-level testbench for the keystroke cursor editor: stimulus, handshakes and checking.
`timescale 1ns / 100ps
module keystroke_lcd_cursor_editor_unit_tb;

   localparam int LINE_COLUMNS = 16;
   // Generous bound: about 210 keys, three writes each, half the cycles stalled on
   // both sides, plus the long hold-off and the drain pauses, taken many times over.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_KEYS  = 160;
   localparam int HOLD_CYCLES  = 300;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic [7:0] req_key_code     = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic       rsp_is_char_data;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_write;

   // Percentages of cycles in which the key sender idles and the display side stalls.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // Remaining cycles of a forced display-side hold-off, counted down below.
   int hold_left      = 0;
   int cycle_count    = 0;
   int input_stalls   = 0;

   cursor_write_scoreboard_pkg::cursor_write_scoreboard sb = new(LINE_COLUMNS);

   keystroke_lcd_cursor_editor_unit #(
      .LINE_COLUMNS(LINE_COLUMNS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key_code    (req_key_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_char_data(rsp_is_char_data),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_write  (rsp_last_write)
   );

   always #4 clock = ~clock;

   // The run is cut off if it ever goes this long; a correct block finishes far sooner.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("keystroke_lcd_cursor_editor_unit_tb: done, errors");
         $finish;
      end
   end

   // Display side: either the forced hold-off is counting down, or ready is drawn
   // at random each cycle according to the current stall percentage.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // One monitor handles both channels at each edge. The key beat is noted first,
   // so that any write at the same edge always finds its expectation already queued.
   // All values read here are the ones that stood just before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_key(req_key_code);
         if (req_valid && !req_ready)
            input_stalls++;
         if (rsp_valid && rsp_ready)
            sb.check_write(rsp_is_char_data, rsp_out_byte, rsp_last_write);
      end
   end

   // Offers one key beat and returns at the edge where it is taken. Valid stays high
   // after acceptance, so back-to-back keys never lower and raise it in one step; it
   // only drops when the sender actually idles.
   task automatic send_key(input logic [7:0] key);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_key_code <= key;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering keys until every expected display write has been seen. The first
   // edge lets the monitor note the last key before the count is looked at.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // A run of random keys, mostly keys that act, with the occasional stray code.
   // Only keys that cause writes count toward the total.
   task automatic random_keys(input int count);
      int         acted;
      int         pick;
      logic [7:0] key;
      acted = 0;
      while (acted < count) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            key = 8'($urandom_range(kce_pkg::PRINT_LOW, kce_pkg::PRINT_HIGH));
         end else if (pick < 72) begin
            case ($urandom_range(3))
               0: key = kce_pkg::KEY_UP;
               1: key = kce_pkg::KEY_DOWN;
               2: key = kce_pkg::KEY_LEFT;
               default: key = kce_pkg::KEY_RIGHT;
            endcase
         end else if (pick < 88) begin
            key = kce_pkg::KEY_BACKSPACE;
         end else begin
            key = 8'($urandom_range(255));
         end
         if (key inside {kce_pkg::KEY_BACKSPACE, kce_pkg::KEY_UP, kce_pkg::KEY_DOWN,
                         kce_pkg::KEY_LEFT, kce_pkg::KEY_RIGHT,
                         [kce_pkg::PRINT_LOW:kce_pkg::PRINT_HIGH]})
            acted++;
         send_key(key);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk. It starts with backspace at home, hits the printable bounds and
      // a spread of codes that must be ignored (all bits set and all clear among them),
      // then steers the cursor into each wrap: left off column zero, a character typed
      // in the last column, right off the last column, and backspace from the start
      // of the lower line.
      send_key(kce_pkg::KEY_BACKSPACE);
      send_key(kce_pkg::PRINT_LOW);
      send_key(kce_pkg::PRINT_HIGH);
      send_key(8'h00);
      send_key(8'hFF);
      send_key(8'h1F);
      send_key(8'h7F);
      send_key(8'hE4);
      send_key(8'hDF);
      send_key(8'h07);
      send_key(8'h09);
      send_key(kce_pkg::KEY_UP);
      send_key(kce_pkg::KEY_LEFT);
      send_key(kce_pkg::KEY_LEFT);
      send_key(kce_pkg::KEY_LEFT);
      send_key(8'h41);
      send_key(kce_pkg::KEY_LEFT);
      send_key(kce_pkg::KEY_RIGHT);
      send_key(kce_pkg::KEY_DOWN);
      send_key(kce_pkg::KEY_BACKSPACE);
      send_key(kce_pkg::KEY_RIGHT);
      send_key(kce_pkg::KEY_BACKSPACE);
      send_key(kce_pkg::KEY_BACKSPACE);
      send_key(8'h55);
      wait_drained();

      // Hold the display side off for a long stretch while keys keep coming, so the
      // queue fills and the block has to stall its key input.
      hold_left <= HOLD_CYCLES;
      repeat (12) send_key(8'($urandom_range(kce_pkg::PRINT_LOW, kce_pkg::PRINT_HIGH)));
      wait_drained();

      // Random keys under four idling patterns, draining between them.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_keys(RANDOM_KEYS / 4);
      wait_drained();

      send_idle_pct  = 49;
      recv_stall_pct = 0;
      random_keys(RANDOM_KEYS / 4);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 49;
      random_keys(RANDOM_KEYS / 4);
      wait_drained();

      send_idle_pct  = 17;
      recv_stall_pct = 17;
      random_keys(RANDOM_KEYS / 4);
      wait_drained();

      // Let any stray write that should not exist show up before the verdict.
      recv_stall_pct = 0;
      repeat (20) @(posedge clock);

      // Writes that were predicted but never came are errors too.
      if (sb.pending() != 0) begin
         $error("display writes missing: expected %0d more, got 0", sb.pending());
         sb.errors++;
      end

      $display("Covered %0d keys (%0d ignored), %0d display writes checked.",
               sb.keys_noted, sb.ignored_keys, sb.writes_checked);
      $display("Typing wraps %0d, home backspaces %0d, backspaces to line 0 %0d, %s %0d.",
               sb.line_wraps, sb.backspace_home, sb.backspace_wrap, "key stall cycles",
               input_stalls);
      if (sb.errors == 0)
         $display("keystroke_lcd_cursor_editor_unit_tb: done, clean");
      else
         $display("keystroke_lcd_cursor_editor_unit_tb: done, errors");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/kce_pkg.sv
hw/rtl/kce_front.sv
hw/rtl/kce_queue.sv
hw/rtl/kce_back.sv
hw/rtl/keystroke_lcd_cursor_editor_unit.sv
hw/rtl/kce_checker.sv
tb/cursor_write_scoreboard_pkg.sv
tb/keystroke_lcd_cursor_editor_unit_tb.sv
